// ===== src/ddfp_pkg.sv =====
// Package for the decimal degree parser: phase codes, character codes,
// fraction digit weights and the per-field result struct.
// No dependencies.
`timescale 1ns / 1ps

package ddfp_pkg;

  localparam int FRACTION_DIGITS = 7;    // up to 7 fraction digits kept
  localparam int WHOLE_LIMIT     = 181;  // largest accepted integer part

  localparam logic [23:0] DEG_SCALE  = 24'd10000000;
  localparam logic [7:0]  CHAR_ZERO  = 8'h30;
  localparam logic [7:0]  CHAR_NINE  = 8'h39;
  localparam logic [7:0]  CHAR_POINT = 8'h2E;

  // parse phase codes
  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_WHOLE = 2'd1;
  localparam logic [1:0] PH_FRAC  = 2'd2;
  localparam logic [1:0] PH_SKIP  = 2'd3;

  // finished field, before scaling
  typedef struct packed {
    logic [7:0]  whole;
    logic [23:0] frac;
    logic        bad;
  } field_result_t;

  // weight of the fraction digit at a given position: 10^6 down to 1
  function automatic logic [23:0] frac_weight(input logic [2:0] pos);
    logic [23:0] w;
    unique case (pos)
      3'd0:    w = 24'd1000000;
      3'd1:    w = 24'd100000;
      3'd2:    w = 24'd10000;
      3'd3:    w = 24'd1000;
      3'd4:    w = 24'd100;
      3'd5:    w = 24'd10;
      3'd6:    w = 24'd1;
      default: w = 24'd0;
    endcase
    return w;
  endfunction

endpackage

// ===== src/ddfp_parse.sv =====
// Per-character parse state of the degree field and its update logic.
// Gives the finished field combinationally on the field's last character.
// Depends on ddfp_pkg.
`timescale 1ns / 1ps

module ddfp_parse #(
  parameter int FRACTION_DIGITS = ddfp_pkg::FRACTION_DIGITS,
  parameter int WHOLE_LIMIT     = ddfp_pkg::WHOLE_LIMIT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  logic [7:0]             char_code,
  input  logic                   last_char,
  output ddfp_pkg::field_result_t result
);

  logic [1:0]  phase, phase_next;
  logic [7:0]  whole, whole_next;
  logic [23:0] frac, frac_next;
  logic [2:0]  count, count_next;
  logic        err, err_next;

  logic        digit;
  logic [3:0]  dval;
  logic [11:0] whole_mac;
  logic        done_field_bad;

  assign digit     = (char_code >= ddfp_pkg::CHAR_ZERO) && (char_code <= ddfp_pkg::CHAR_NINE);
  assign dval      = digit ? 4'(char_code - ddfp_pkg::CHAR_ZERO) : 4'd0;
  assign whole_mac = 12'(whole) * 12'd10 + 12'(dval);

  always_comb begin
    phase_next = phase;
    whole_next = whole;
    frac_next  = frac;
    count_next = count;
    err_next   = err;
    unique case (phase)
      ddfp_pkg::PH_START: begin
        if (digit) begin
          whole_next = 8'(dval);
          phase_next = ddfp_pkg::PH_WHOLE;
        end else begin
          err_next   = 1'b1;
          phase_next = ddfp_pkg::PH_SKIP;
        end
      end
      ddfp_pkg::PH_WHOLE: begin
        if (digit) begin
          whole_next = (whole_mac > 12'd255) ? 8'd255 : whole_mac[7:0];
        end else if (char_code == ddfp_pkg::CHAR_POINT &&
                     whole <= 8'(WHOLE_LIMIT)) begin
          phase_next = ddfp_pkg::PH_FRAC;
        end else begin
          err_next   = 1'b1;
          phase_next = ddfp_pkg::PH_SKIP;
        end
      end
      ddfp_pkg::PH_FRAC: begin
        if (digit) begin
          if (4'(count) < 4'(FRACTION_DIGITS)) begin
            frac_next  = frac + 24'(dval) * ddfp_pkg::frac_weight(count);
            count_next = count + 3'd1;
          end
          if (4'(count_next) >= 4'(FRACTION_DIGITS)) begin
            phase_next = ddfp_pkg::PH_SKIP;
          end
        end else begin
          phase_next = ddfp_pkg::PH_SKIP;
        end
      end
      default: ;
    endcase
  end

  // field ending before its point is malformed
  assign done_field_bad = err_next || (phase_next == ddfp_pkg::PH_START) ||
                          (phase_next == ddfp_pkg::PH_WHOLE);

  assign result.whole = whole_next;
  assign result.frac  = frac_next;
  assign result.bad   = done_field_bad;

  always_ff @(posedge clk) begin
    if (rst || (fire && last_char)) begin
      phase <= ddfp_pkg::PH_START;
      whole <= 8'd0;
      frac  <= 24'd0;
      count <= 3'd0;
      err   <= 1'b0;
    end else if (fire) begin
      phase <= phase_next;
      whole <= whole_next;
      frac  <= frac_next;
      count <= count_next;
      err   <= err_next;
    end
  end

  // a field always starts from a clean state
  a_restart: assert property (@(posedge clk) disable iff (rst)
    fire && last_char |=> phase == ddfp_pkg::PH_START && count == 3'd0 && !err)
    else $error("parser did not restart after last character");

endmodule

// ===== src/decimal_degree_to_fixed_parser.sv =====
// A result passes the input, field result and output registers, in that order.
// Throughput: one character per cycle while no held last character waits for room in
// the field register; each register moves on its own, so bubbles between fields collapse.
// The parse state is updated once per character by a single pass of logic.
// Reset (synchronous, active high) empties all stages and starts a new field.
// Depends on ddfp_pkg and ddfp_parse.
`timescale 1ns / 1ps

module decimal_degree_to_fixed_parser #(
  parameter int FRACTION_DIGITS = ddfp_pkg::FRACTION_DIGITS,
  parameter int WHOLE_LIMIT     = ddfp_pkg::WHOLE_LIMIT
) (
  input  logic        clk,
  input  logic        rst,
  // character channel
  input  logic        char_valid,
  output logic        char_stall,
  input  logic [7:0]  char_code,
  input  logic        last_char,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [30:0] fixed_degrees,
  output logic        bad_field
);

  // input register
  logic       in_valid;
  logic [7:0] in_code;
  logic       in_last;

  // field result register (one entry per finished field)
  logic                    fld_valid;
  ddfp_pkg::field_result_t fld;
  ddfp_pkg::field_result_t fld_next;

  logic out_free;   // output register can take a new result
  logic fld_free;   // field register can take a new field
  logic in_fire;    // held character is applied to the parse state
  logic in_take;    // a new character transfer happens this cycle

  logic [31:0] scaled;

  assign out_free = !result_valid || !result_stall;
  assign fld_free = !fld_valid || out_free;
  // only a last character needs room downstream; others just update state
  assign in_fire  = in_valid && (!in_last || fld_free);
  assign char_stall = in_valid && !in_fire;
  assign in_take  = char_valid && !char_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_take) begin
      in_valid <= 1'b1;
    end else if (in_fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_code <= char_code;
      in_last <= last_char;
    end
  end

  ddfp_parse #(
    .FRACTION_DIGITS (FRACTION_DIGITS),
    .WHOLE_LIMIT     (WHOLE_LIMIT)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .fire      (in_fire),
    .char_code (in_code),
    .last_char (in_last),
    .result    (fld_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fld_valid <= 1'b0;
    end else if (in_fire && in_last) begin
      fld_valid <= 1'b1;
    end else if (out_free) begin
      fld_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_last) begin
      fld <= fld_next;
    end
  end

  // degrees * 10^7 + fraction; integer part is at most the limit when good
  assign scaled = 32'(fld.whole) * 32'(ddfp_pkg::DEG_SCALE) + 32'(fld.frac);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= fld_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && fld_valid) begin
      fixed_degrees <= fld.bad ? 31'd0 : scaled[30:0];
      bad_field     <= fld.bad;
    end
  end

  // a bad field never carries a value
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && bad_field |-> fixed_degrees == 31'd0)
    else $error("bad field with nonzero value");

  // a good field stays below (limit + 1) degrees
  a_good_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && !bad_field |->
      32'(fixed_degrees) < 32'(WHOLE_LIMIT + 1) * 32'(ddfp_pkg::DEG_SCALE))
    else $error("good field out of range");

  // a finished field waiting on a stalled output is not dropped
  a_fld_hold: assert property (@(posedge clk) disable iff (rst)
    fld_valid && !out_free |=> fld_valid && $stable(fld))
    else $error("field result lost while output stalled");

endmodule
